// File: sv/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and saturation helpers for the two-state tracker.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int W   = 32;  // Q16.16 word
  localparam int MW  = 33;  // multiplier operand width
  localparam int PW  = 66;  // product width
  localparam int XW  = 68;  // wide working width for sums before saturation
  localparam int DNW = 36;  // innovation variance width
  localparam int DVW = 48;  // dividend / quotient width
  localparam int DSW = 35;  // divisor magnitude width
  localparam int IXW = 3;   // config index width

  localparam logic [IXW-1:0] REG_PROC_NOISE = 3'd0;
  localparam logic [IXW-1:0] REG_MEAS_NOISE = 3'd1;
  localparam logic [IXW-1:0] REG_INIT_COV   = 3'd2;
  localparam logic [IXW-1:0] REG_INIT_FIRST = 3'd3;
  localparam logic [IXW-1:0] REG_INIT_SEC   = 3'd4;
  localparam logic [IXW-1:0] REG_DIFF_GAIN  = 3'd5;

  localparam logic [30:0] PROC_NOISE_RST = 31'd655;
  localparam logic [30:0] MEAS_NOISE_RST = 31'd65536;
  localparam logic [30:0] INIT_COV_RST   = 31'd65536;
  localparam logic [15:0] DIFF_GAIN_RST  = 16'd10000;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] coef_first;
    logic signed [15:0] coef_second;
    logic               restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] second_estimate;
    logic [31:0]        squared_innovation;
    logic [31:0]        third_difference;
    logic               difference_valid;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC_A, ST_DIV0, ST_DIV1, ST_CALC_B, ST_DONE
  } state_t;

  // One multiply per step, except SP_END; name gives the operand pair.
  typedef enum logic [4:0] {
    SP_P0C0, SP_P2C1, SP_P1C0, SP_P3C1, SP_P1C1, SP_P2C0,
    SP_SAC0, SP_SBC1, SP_C0E0, SP_C1E1,
    SP_K0I, SP_K1I, SP_K0SA, SP_K0SB, SP_K1SA, SP_K1SB,
    SP_II, SP_MG, SP_END
  } step_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  function automatic logic signed [W-1:0] sat32(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'(32'sh7FFFFFFF);
    lo = XW'(32'sh80000000);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[W-1:0];
  endfunction

  // Non-negative input only.
  function automatic logic [W-1:0] satu32(input logic signed [XW-1:0] v);
    if (v[XW-1:W] != '0) return '1;
    else return v[W-1:0];
  endfunction

endpackage

// File: sv/two_state_kalman_sinusoid_tracker_unit.sv
// ----------------------------------------------------------------------------
// two_state_kalman_sinusoid_tracker_unit
// Two-state Kalman tracker: one sample in, one estimate/innovation beat out.
// ----------------------------------------------------------------------------
// One item at a time. Each beat makes 18 passes through the single 33x33
// multiplier (one per cycle in the calculate states) and two gain divisions
// on the bit-serial divider (48 quotient bits each). The input is stalled
// from accept until the result is loaded into the output register; a
// result waiting downstream does not block the next accept. The user must
// make config writes only while idle; the block itself does not enforce
// it. The initial-state registers apply at the next restart.
module two_state_kalman_sinusoid_tracker_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  kst_pkg::in_beat_t      in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output kst_pkg::out_beat_t     out_data,
  input  logic                   cfg_we,
  input  logic [kst_pkg::IXW-1:0] cfg_index,
  input  logic [kst_pkg::W-1:0]  cfg_wdata
);
  import kst_pkg::*;

  // config
  logic [30:0]        q_r, r_r, pinit_r;
  logic signed [31:0] e0init_r, e1init_r;
  logic [15:0]        gain_r;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  in_beat_t in_r;
  logic signed [W-1:0] p0_r, p1_r, p2_r, p3_r, e0_r, e1_r;
  logic signed [W-1:0] h0_r, h1_r, h2_r;
  logic [1:0]          cnt_r;
  logic signed [W-1:0] p0c0_r, p1c0_r, p3c1_r, sa_r, sb_r, n0_r, n1_r;
  logic signed [W-1:0] inno_r, k0_r, k1_r;
  logic signed [DNW-1:0] den_r, pred_r;
  logic [W-1:0]        sq_r, td_r;
  logic [DSW-1:0]      mag_r;
  logic                mag_big_r;

  logic signed [MW-1:0] opa, opb;
  logic signed [PW-1:0] prod_r, sh14, sh16;
  logic signed [XW-1:0] x14, x16;
  logic signed [W-1:0]  s14;
  step_t                pstep_r;
  logic                 pv_r, do_mul;

  logic                 accept, fire_out;
  out_beat_t            out_r;
  logic                 out_valid_r;

  div_ctl_t             dctl;
  logic [DVW-1:0]       dvd, quo;
  logic signed [W-1:0]  nsel, kval;
  logic [W-1:0]         nabs;
  logic signed [DNW-1:0] d3;
  logic [DSW-1:0]       mag;

  // ---------------- config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r      <= PROC_NOISE_RST;
      r_r      <= MEAS_NOISE_RST;
      pinit_r  <= INIT_COV_RST;
      e0init_r <= '0;
      e1init_r <= '0;
      gain_r   <= DIFF_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PROC_NOISE: q_r      <= cfg_wdata[30:0];
        REG_MEAS_NOISE: r_r      <= cfg_wdata[30:0];
        REG_INIT_COV:   pinit_r  <= cfg_wdata[30:0];
        REG_INIT_FIRST: e0init_r <= $signed(cfg_wdata);
        REG_INIT_SEC:   e1init_r <= $signed(cfg_wdata);
        REG_DIFF_GAIN:  gain_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer
  assign accept   = in_valid && !in_stall;
  assign fire_out = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CALC_A;
          step_nxt  = SP_P0C0;
        end
      end
      ST_CALC_A: begin
        if (step_r == SP_K0I) state_nxt = ST_DIV0;
        else step_nxt = step_t'(step_r + 1'b1);
      end
      ST_DIV0: if (dctl.done) state_nxt = ST_DIV1;
      ST_DIV1: if (dctl.done) state_nxt = ST_CALC_B;
      ST_CALC_B: begin
        if (step_r == SP_END) state_nxt = ST_DONE;
        else step_nxt = step_t'(step_r + 1'b1);
      end
      ST_DONE: if (fire_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    do_mul     = ((state_r == ST_CALC_A) && (step_r != SP_K0I)) ||
                 ((state_r == ST_CALC_B) && (step_r != SP_END));
  end

  assign dctl.start = ((state_r == ST_CALC_A) && (step_r == SP_K0I)) ||
                      ((state_r == ST_DIV0) && dctl.done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= SP_P0C0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pv_r    <= do_mul;
    end
  end

  // ---------------- shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (step_r)
      SP_P0C0: begin opa = MW'(p0_r); opb = MW'(in_r.coef_first);  end
      SP_P2C1: begin opa = MW'(p2_r); opb = MW'(in_r.coef_second); end
      SP_P1C0: begin opa = MW'(p1_r); opb = MW'(in_r.coef_first);  end
      SP_P3C1: begin opa = MW'(p3_r); opb = MW'(in_r.coef_second); end
      SP_P1C1: begin opa = MW'(p1_r); opb = MW'(in_r.coef_second); end
      SP_P2C0: begin opa = MW'(p2_r); opb = MW'(in_r.coef_first);  end
      SP_SAC0: begin opa = MW'(sa_r); opb = MW'(in_r.coef_first);  end
      SP_SBC1: begin opa = MW'(sb_r); opb = MW'(in_r.coef_second); end
      SP_C0E0: begin opa = MW'(e0_r); opb = MW'(in_r.coef_first);  end
      SP_C1E1: begin opa = MW'(e1_r); opb = MW'(in_r.coef_second); end
      SP_K0I:  begin opa = MW'(k0_r); opb = MW'(inno_r); end
      SP_K1I:  begin opa = MW'(k1_r); opb = MW'(inno_r); end
      SP_K0SA: begin opa = MW'(k0_r); opb = MW'(sa_r);   end
      SP_K0SB: begin opa = MW'(k0_r); opb = MW'(sb_r);   end
      SP_K1SA: begin opa = MW'(k1_r); opb = MW'(sa_r);   end
      SP_K1SB: begin opa = MW'(k1_r); opb = MW'(sb_r);   end
      SP_II:   begin opa = MW'(inno_r); opb = MW'(inno_r); end
      SP_MG:   begin opa = $signed({1'b0, mag_r[W-1:0]});
                     opb = $signed({17'b0, gain_r}); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_mul) begin
      prod_r  <= opa * opb;
      pstep_r <= step_r;
    end
  end

  assign sh14 = prod_r >>> 14;
  assign sh16 = prod_r >>> 16;
  assign x14  = XW'(sh14);
  assign x16  = XW'(sh16);
  assign s14  = sat32(x14);

  // ---------------- divider and gain sign/saturation
  assign nsel = (state_r == ST_DIV0) ? n1_r : n0_r;
  assign nabs = nsel[W-1] ? (~nsel + 1'b1) : nsel;
  assign dvd  = {nabs, 16'b0};

  kst_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dctl.start),
    .dividend (dvd),
    .divisor  (den_r[DSW-1:0]),
    .busy     (dctl.busy),
    .done     (dctl.done),
    .quotient (quo)
  );

  always_comb begin
    logic neg;
    neg = (state_r == ST_DIV0) ? n0_r[W-1] : n1_r[W-1];
    if (den_r <= 0) kval = '0;
    else if (neg) kval = (quo > DVW'(48'd2147483648)) ? 32'sh80000000 : -$signed(quo[W-1:0]);
    else kval = (quo > DVW'(48'd2147483647)) ? 32'sh7FFFFFFF : $signed(quo[W-1:0]);
  end

  // third difference of the second state, from the fresh estimate
  assign d3  = DNW'(e1_r) - (DNW'(h0_r) <<< 1) - DNW'(h0_r)
             + (DNW'(h1_r) <<< 1) + DNW'(h1_r) - DNW'(h2_r);
  assign mag = d3[DNW-1] ? DSW'(-d3) : DSW'(d3);

  // ---------------- datapath state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_r  <= $signed({1'b0, INIT_COV_RST});
      p1_r  <= '0;
      p2_r  <= '0;
      p3_r  <= $signed({1'b0, INIT_COV_RST});
      e0_r  <= '0;
      e1_r  <= '0;
      h0_r  <= '0;
      h1_r  <= '0;
      h2_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (accept) begin
        // reload on restart, then process noise onto the diagonal
        if (in_data.restart) begin
          p0_r  <= sat32(XW'($signed({1'b0, pinit_r})) + XW'($signed({1'b0, q_r})));
          p3_r  <= sat32(XW'($signed({1'b0, pinit_r})) + XW'($signed({1'b0, q_r})));
          p1_r  <= '0;
          p2_r  <= '0;
          e0_r  <= e0init_r;
          e1_r  <= e1init_r;
          h0_r  <= '0;
          h1_r  <= '0;
          h2_r  <= '0;
          cnt_r <= '0;
        end else begin
          p0_r <= sat32(XW'(p0_r) + XW'($signed({1'b0, q_r})));
          p3_r <= sat32(XW'(p3_r) + XW'($signed({1'b0, q_r})));
        end
      end
      if (pv_r) begin
        unique case (pstep_r)
          SP_K0I:  e0_r <= sat32(XW'(e0_r) + x16);
          SP_K1I:  e1_r <= sat32(XW'(e1_r) + x16);
          SP_K0SA: p0_r <= sat32(XW'(p0_r) - x16);
          SP_K0SB: p1_r <= sat32(XW'(p1_r) - x16);
          SP_K1SA: p2_r <= sat32(XW'(p2_r) - x16);
          SP_K1SB: p3_r <= sat32(XW'(p3_r) - x16);
          default: ;
        endcase
      end
      if (fire_out) begin
        h2_r <= h1_r;
        h1_r <= h0_r;
        h0_r <= e1_r;
        if (cnt_r != 2'd3) cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
    if (pv_r) begin
      unique case (pstep_r)
        SP_P0C0: p0c0_r <= s14;
        SP_P2C1: sa_r   <= sat32(XW'(p0c0_r) + XW'(s14));
        SP_P1C0: p1c0_r <= s14;
        SP_P3C1: begin
          p3c1_r <= s14;
          sb_r   <= sat32(XW'(p1c0_r) + XW'(s14));
        end
        SP_P1C1: n0_r   <= sat32(XW'(p0c0_r) + XW'(s14));
        SP_P2C0: n1_r   <= sat32(XW'(s14) + XW'(p3c1_r));
        SP_SAC0: den_r  <= DNW'(sh14);
        SP_SBC1: den_r  <= DNW'(XW'(den_r) + x14 + XW'($signed({1'b0, r_r})));
        SP_C0E0: pred_r <= DNW'(sh14);
        SP_C1E1: inno_r <= sat32((XW'(in_r.sample) <<< 16) - XW'(pred_r) - x14);
        SP_II:   sq_r   <= satu32(x16);
        SP_MG:   td_r   <= mag_big_r ? ((gain_r != '0) ? '1 : '0) : satu32(XW'(prod_r));
        default: ;
      endcase
    end
    if (state_r == ST_DIV0 && dctl.done) k0_r <= kval;
    if (state_r == ST_DIV1 && dctl.done) k1_r <= kval;
    if (state_r == ST_CALC_B && step_r == SP_K0SB) begin
      mag_r     <= mag;
      mag_big_r <= (mag[DSW-1:W] != '0);
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_out) begin
      out_r.second_estimate    <= e1_r;
      out_r.squared_innovation <= sq_r;
      out_r.third_difference   <= (cnt_r == 2'd3) ? td_r : '0;
      out_r.difference_valid   <= (cnt_r == 2'd3);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CALC_A) && (step_r == SP_P0C0))
    else $error("accept did not start the sequence");
  a_div_done_state : assert property (@(posedge clk) disable iff (!rst_n)
    dctl.done |-> (state_r == ST_DIV0) || (state_r == ST_DIV1))
    else $error("divider finished outside a divide state");
  a_no_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !dctl.busy)
    else $error("divider restarted while busy");
  a_fire_loads_out : assert property (@(posedge clk) disable iff (!rst_n)
    fire_out |=> out_valid_r && (state_r == ST_IDLE))
    else $error("result not presented after completion");
`endif

endmodule

// File: sv/kst_div.sv
// ----------------------------------------------------------------------------
// kst_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kst_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [kst_pkg::DVW-1:0]  dividend,
  input  logic [kst_pkg::DSW-1:0]  divisor,
  output logic                     busy,
  output logic                     done,
  output logic [kst_pkg::DVW-1:0]  quotient
);
  import kst_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DVW-1:0]  dq_r, dq_nxt;     // dividend shifts out, quotient shifts in
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DSW-1:0]  dsr_r;
  logic [DSW:0]    trial;

  assign trial = {rem_r, dq_r[DVW-1]};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DVW);
      dq_nxt   = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DSW'(trial - {1'b0, dsr_r});
        dq_nxt  = {dq_r[DVW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DSW-1:0];
        dq_nxt  = {dq_r[DVW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    if (start) dsr_r <= divisor;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dq_r;

endmodule
